FILE: src/nfba_pkg.sv
// ----------------------------------------------------------------------------
// nfba_pkg
// Shared types and constants for the next-fit bitmap block allocator.
// ----------------------------------------------------------------------------
package nfba_pkg;

    // field widths
    localparam int BLK_W    = 12;  // block number as carried on the ports
    localparam int IBLK_W   = 13;  // internal block number, holds the device end
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;

    // largest usable end the 13-bit total_blocks register can express
    localparam int MAX_END = 8191;

    // reciprocal divide: exact for 13-bit dividends and divisors up to 64
    localparam int DIV_SHIFT = 20;

    // action codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS = 2'd1;

    // register reset values
    localparam logic [BLK_W-1:0]  REGION_START_RST = 12'd1;
    localparam logic [IBLK_W-1:0] TOTAL_BLOCKS_RST = 13'd4096;

    typedef struct packed {
        logic             action;
        logic [BLK_W-1:0] block_number;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BLK_W-1:0]    granted_block;
    } result_t;

endpackage

FILE: src/next_fit_bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// next_fit_bitmap_block_allocator
// Next-fit block allocator over a one-bit-per-block used map.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a beat is taken when start is high and busy is low.
//   cmd.action selects allocate or free; cmd.block_number is the block to free.
//   Each command gives exactly one result beat: done is high for one cycle
//   with result valid. The receiver cannot stall; results are not held.
//   Config channel: cfg_index/cfg_data written when cfg_valid and cfg_ready
//   (always ready). Write only while idle. Writing the region start also
//   moves the next-fit cursor there.
// Sequence:
//   Free: the block number passes the divider (S_DIV0, S_DIV1), its map word is
//   read (S_RDADDR) and the bit is cleared in S_FREE. Allocate runs the same
//   steps, then S_SCAN tests one word per cycle through the shared scan unit and
//   the single map read port; a search that wraps to the region start passes the
//   divider and the read again. An empty region, or a free outside the region, is
//   answered from idle without the map. A full map is scanned through.
// Reset:
//   The map is cleared by a pass of one word per cycle over ceil(min(NUM_BLOCKS,
//   8191)/WORD_BITS) map words (64 by default); busy stays high meanwhile.
// ----------------------------------------------------------------------------
module next_fit_bitmap_block_allocator #(
    parameter int NUM_BLOCKS = 4096,
    parameter int WORD_BITS  = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  nfba_pkg::cmd_t                    cmd,
    output logic                              done,
    output nfba_pkg::result_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nfba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nfba_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int IW      = nfba_pkg::IBLK_W;
    localparam int BW      = nfba_pkg::BLK_W;
    localparam int END_CAP = (NUM_BLOCKS < nfba_pkg::MAX_END) ? NUM_BLOCKS : nfba_pkg::MAX_END;
    localparam int MEM_WORDS = (END_CAP + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W  = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam logic [IW-1:0]     END_CAP_V = IW'(END_CAP);
    localparam logic [IW:0]       WB_V      = (IW+1)'(WORD_BITS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_WORDS - 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DIV0   = 3'd2;
    localparam logic [2:0] S_DIV1   = 3'd3;
    localparam logic [2:0] S_RDADDR = 3'd4;
    localparam logic [2:0] S_SCAN   = 3'd5;
    localparam logic [2:0] S_FREE   = 3'd6;

    logic [2:0]                 state_reg, state_next;
    logic                       act_reg, act_next;
    logic [IW-1:0]              lo_reg, lo_next;
    logic [IW-1:0]              hi_reg, hi_next;
    logic [IW-1:0]              start_reg, start_next;
    logic                       wrap_reg, wrap_next;
    logic [ADDR_W-1:0]          addr_reg, addr_next;
    logic [IW-1:0]              base_reg, base_next;
    logic [BW-1:0]              ds_reg, ds_next;
    logic [IW-1:0]              tb_reg, tb_next;
    logic [BW-1:0]              cursor_reg, cursor_next;
    logic                       done_reg, done_next;
    nfba_pkg::result_t          res_reg, res_next;

    logic [WORD_BITS-1:0]       mem [MEM_WORDS];
    logic [WORD_BITS-1:0]       rd_data_reg;
    logic [ADDR_W-1:0]          mem_raddr;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [WORD_BITS-1:0]       mem_wdata;

    logic [IW-1:0]              div_quot;
    logic [IW-1:0]              div_base;
    logic                       scan_found;
    logic [BIT_W-1:0]           scan_bit;
    logic [WORD_BITS-1:0]       scan_word;

    logic [IW-1:0]              end_c;
    logic [IW-1:0]              ds_ext;
    logic [IW-1:0]              cur_ext;
    logic [IW-1:0]              blk_ext;
    logic [IW-1:0]              search_start;
    logic [IW-1:0]              got;
    logic [IW-1:0]              got_inc;
    logic [IW:0]                next_base;
    logic [IW-1:0]              free_off;
    logic [BIT_W-1:0]           free_bit;
    logic                       cfg_we;

    assign end_c   = (tb_reg < END_CAP_V) ? tb_reg : END_CAP_V;
    assign ds_ext  = IW'(ds_reg);
    assign cur_ext = IW'(cursor_reg);
    assign blk_ext = IW'(cmd.block_number);
    assign search_start = (cur_ext < ds_ext || cur_ext >= end_c) ? ds_ext : cur_ext;
    assign got       = base_reg + IW'(scan_bit);
    assign got_inc   = got + IW'(1);
    assign next_base = (IW+1)'(base_reg) + WB_V;
    assign free_off  = lo_reg - base_reg;
    assign free_bit  = free_off[BIT_W-1:0];
    assign cfg_we    = cfg_valid && cfg_ready;

    nfba_div #(
        .WORD_BITS (WORD_BITS)
    ) u_div (
        .clk  (clk),
        .num  (lo_reg),
        .quot (div_quot),
        .base (div_base)
    );

    nfba_scan #(
        .WORD_BITS (WORD_BITS)
    ) u_scan (
        .word     (rd_data_reg),
        .base     (base_reg),
        .lo       (lo_reg),
        .hi       (hi_reg),
        .found    (scan_found),
        .bit_idx  (scan_bit),
        .set_word (scan_word)
    );

    // map memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        start_next  = start_reg;
        wrap_next   = wrap_reg;
        addr_next   = addr_reg;
        base_next   = base_reg;
        ds_next     = ds_reg;
        tb_next     = tb_reg;
        cursor_next = cursor_reg;
        done_next   = 1'b0;
        res_next    = res_reg;
        mem_raddr   = addr_reg;
        mem_we      = 1'b0;
        mem_waddr   = addr_reg;
        mem_wdata   = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                addr_next = addr_reg + ADDR_W'(1);
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    act_next = cmd.action;
                    if (cmd.action == nfba_pkg::ACT_FREE)
                    begin
                        if (blk_ext < ds_ext || blk_ext >= end_c)
                        begin
                            done_next = 1'b1;
                            res_next  = '{status: nfba_pkg::ST_BAD_FREE, granted_block: '0};
                        end
                        else
                        begin
                            lo_next    = blk_ext;
                            state_next = S_DIV0;
                        end
                    end
                    else
                    begin
                        if (ds_ext >= end_c)
                        begin
                            done_next = 1'b1;
                            res_next  = '{status: nfba_pkg::ST_FULL, granted_block: '0};
                        end
                        else
                        begin
                            lo_next    = search_start;
                            hi_next    = end_c;
                            start_next = search_start;
                            wrap_next  = 1'b0;
                            state_next = S_DIV0;
                        end
                    end
                end
            end
            S_DIV0:
            begin
                state_next = S_DIV1;
            end
            S_DIV1:
            begin
                state_next = S_RDADDR;
            end
            S_RDADDR:
            begin
                mem_raddr  = div_quot[ADDR_W-1:0];
                addr_next  = div_quot[ADDR_W-1:0];
                base_next  = div_base;
                state_next = (act_reg == nfba_pkg::ACT_FREE) ? S_FREE : S_SCAN;
            end
            S_SCAN:
            begin
                mem_raddr = addr_reg + ADDR_W'(1);
                if (scan_found)
                begin
                    mem_we      = 1'b1;
                    mem_wdata   = scan_word;
                    cursor_next = (got_inc >= end_c) ? ds_reg : got_inc[BW-1:0];
                    done_next   = 1'b1;
                    res_next    = '{status: nfba_pkg::ST_OK, granted_block: got[BW-1:0]};
                    state_next  = S_IDLE;
                end
                else if (next_base >= (IW+1)'(hi_reg))
                begin
                    // end of window: wrap once to the region start if the search began above it, else full
                    if (!wrap_reg && start_reg > ds_ext)
                    begin
                        lo_next    = ds_ext;
                        hi_next    = start_reg;
                        wrap_next  = 1'b1;
                        state_next = S_DIV0;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        res_next   = '{status: nfba_pkg::ST_FULL, granted_block: '0};
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    addr_next = addr_reg + ADDR_W'(1);
                    base_next = next_base[IW-1:0];
                end
            end
            S_FREE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (rd_data_reg[free_bit])
                begin
                    mem_we    = 1'b1;
                    mem_wdata = rd_data_reg & ~(WORD_BITS'(1) << free_bit);
                    res_next  = '{status: nfba_pkg::ST_OK, granted_block: '0};
                end
                else
                begin
                    res_next = '{status: nfba_pkg::ST_BAD_FREE, granted_block: '0};
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                nfba_pkg::REG_REGION_START:
                begin
                    ds_next     = cfg_data[BW-1:0];
                    cursor_next = cfg_data[BW-1:0];
                end
                nfba_pkg::REG_TOTAL_BLOCKS:
                begin
                    tb_next = cfg_data[IW-1:0];
                end
                default:
                begin
                    // unknown index: ignored
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            addr_reg   <= '0;
            ds_reg     <= nfba_pkg::REGION_START_RST;
            tb_reg     <= nfba_pkg::TOTAL_BLOCKS_RST;
            cursor_reg <= nfba_pkg::REGION_START_RST;
            done_reg   <= 1'b0;
            act_reg    <= nfba_pkg::ACT_ALLOC;
            wrap_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            ds_reg     <= ds_next;
            tb_reg     <= tb_next;
            cursor_reg <= cursor_next;
            done_reg   <= done_next;
            act_reg    <= act_next;
            wrap_reg   <= wrap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        start_reg <= start_next;
        base_reg  <= base_next;
        res_reg   <= res_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = res_reg;
    assign cfg_ready = 1'b1;

endmodule

FILE: src/nfba_div.sv
// ----------------------------------------------------------------------------
// nfba_div
// Block number to map word: reciprocal multiply, then word base address.
// Quotient register, then base register; the dividend must be held for both cycles.
// ----------------------------------------------------------------------------
module nfba_div #(
    parameter int WORD_BITS = 64
) (
    input  logic                          clk,
    input  logic [nfba_pkg::IBLK_W-1:0]   num,
    output logic [nfba_pkg::IBLK_W-1:0]   quot,
    output logic [nfba_pkg::IBLK_W-1:0]   base
);

    localparam int RECIP = ((1 << nfba_pkg::DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int M_W   = $clog2(RECIP + 1);
    localparam logic [M_W-1:0] RECIP_V = M_W'(RECIP);
    localparam logic [nfba_pkg::IBLK_W-1:0] WB_V = nfba_pkg::IBLK_W'(WORD_BITS);

    logic [nfba_pkg::IBLK_W+M_W-1:0]   prod;
    logic [2*nfba_pkg::IBLK_W-1:0]     bprod;
    logic [nfba_pkg::IBLK_W-1:0]       quot_reg;
    logic [nfba_pkg::IBLK_W-1:0]       base_reg;

    assign prod  = (nfba_pkg::IBLK_W+M_W)'(num) * (nfba_pkg::IBLK_W+M_W)'(RECIP_V);
    assign bprod = (2*nfba_pkg::IBLK_W)'(quot_reg) * (2*nfba_pkg::IBLK_W)'(WB_V);

    always_ff @(posedge clk)
    begin
        quot_reg <= nfba_pkg::IBLK_W'(prod >> nfba_pkg::DIV_SHIFT);
        base_reg <= bprod[nfba_pkg::IBLK_W-1:0];
    end

    assign quot = quot_reg;
    assign base = base_reg;

endmodule

FILE: src/nfba_scan.sv
// ----------------------------------------------------------------------------
// nfba_scan
// One map word against a block window [lo, hi): finds the lowest free bit
// inside the window and returns the word with that bit set.
// ----------------------------------------------------------------------------
module nfba_scan #(
    parameter int WORD_BITS = 64
) (
    input  logic [WORD_BITS-1:0]          word,
    input  logic [nfba_pkg::IBLK_W-1:0]   base,
    input  logic [nfba_pkg::IBLK_W-1:0]   lo,
    input  logic [nfba_pkg::IBLK_W-1:0]   hi,
    output logic                          found,
    output logic [$clog2(WORD_BITS)-1:0]  bit_idx,
    output logic [WORD_BITS-1:0]          set_word
);

    localparam int OFF_W = $clog2(WORD_BITS + 1);
    localparam int BIT_W = $clog2(WORD_BITS);
    localparam logic [nfba_pkg::IBLK_W-1:0] WB_V = nfba_pkg::IBLK_W'(WORD_BITS);

    logic [nfba_pkg::IBLK_W-1:0] lo_diff;
    logic [nfba_pkg::IBLK_W-1:0] hi_diff;
    logic [OFF_W-1:0]            lo_off;
    logic [OFF_W-1:0]            hi_off;
    logic [WORD_BITS-1:0]        cand;

    assign lo_diff = lo - base;
    assign hi_diff = hi - base;

    always_comb
    begin
        // window edges relative to this word, clamped to the word
        if (lo <= base)
            lo_off = '0;
        else if (lo_diff >= WB_V)
            lo_off = OFF_W'(WORD_BITS);
        else
            lo_off = lo_diff[OFF_W-1:0];

        if (hi <= base)
            hi_off = '0;
        else if (hi_diff >= WB_V)
            hi_off = OFF_W'(WORD_BITS);
        else
            hi_off = hi_diff[OFF_W-1:0];

        for (int i = 0; i < WORD_BITS; i++)
            cand[i] = ~word[i] && (OFF_W'(i) >= lo_off) && (OFF_W'(i) < hi_off);
    end

    always_comb
    begin
        found   = 1'b0;
        bit_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                found   = 1'b1;
                bit_idx = BIT_W'(i);
            end
        end
    end

    assign set_word = word | (WORD_BITS'(1) << bit_idx);

endmodule

FILE: bench/next_fit_bitmap_block_allocator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_fit_bitmap_block_allocator_checker
// Watches the command, result and register channels of the allocator, keeps
// its own copy of the used map, cursor and region registers, works out the
// answer to every accepted command and compares it with the result beats.
// ----------------------------------------------------------------------------
module next_fit_bitmap_block_allocator_checker #(
    parameter int NUM_BLOCKS = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  nfba_pkg::cmd_t                      cmd,
    input  logic                                done,
    input  nfba_pkg::result_t                   result,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [nfba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nfba_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  errors,
    output int                                  outstanding
);

    localparam int BW = nfba_pkg::BLK_W;

    bit                          block_used [NUM_BLOCKS];
    logic [BW-1:0]               cursor;
    logic [BW-1:0]               region_start;
    logic [nfba_pkg::IBLK_W-1:0] device_blocks;
    nfba_pkg::result_t           queued_answers[$];
    int                          miss_count;

    // Applies one command to the map copy and returns the answer it owes.
    function automatic nfba_pkg::result_t allocate_or_free(nfba_pkg::cmd_t c);
        nfba_pkg::result_t r;
        int      last;
        int      first;
        int      got;
        last = (int'(device_blocks) < NUM_BLOCKS) ? int'(device_blocks) : NUM_BLOCKS;
        r.status = nfba_pkg::ST_OK;
        r.granted_block = '0;
        if (c.action == nfba_pkg::ACT_ALLOC)
        begin
            first = int'(cursor);
            if (first < int'(region_start) || first >= last)
                first = int'(region_start);
            got = -1;
            for (int b = first; b < last && got < 0; b++)
                if (!block_used[b])
                    got = b;
            // second leg of the next-fit search: wrap back to the region start
            for (int b = int'(region_start); b < first && got < 0; b++)
                if (!block_used[b])
                    got = b;
            if (got >= 0)
            begin
                block_used[got] = 1'b1;
                cursor = (got + 1 >= last) ? region_start : BW'(got + 1);
                r.granted_block = BW'(got);
            end
            else
                r.status = nfba_pkg::ST_FULL;
        end
        else if (c.block_number < region_start || int'(c.block_number) >= last ||
                 !block_used[c.block_number])
            r.status = nfba_pkg::ST_BAD_FREE;
        else
            block_used[c.block_number] = 1'b0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        nfba_pkg::result_t want;
        if (!rst_n)
        begin
            foreach (block_used[i])
                block_used[i] = 1'b0;
            region_start  = nfba_pkg::REGION_START_RST;
            device_blocks = nfba_pkg::TOTAL_BLOCKS_RST;
            cursor        = nfba_pkg::REGION_START_RST;
            queued_answers.delete();
            miss_count    = 0;
        end
        else
        begin
            // a result beat always belongs to an earlier command, so pop first
            if (done)
            begin
                if (queued_answers.size() == 0)
                begin
                    miss_count++;
                    if (miss_count <= 10)
                        $display("%0t: unexpected result st=%0d blk=%0d",
                                 $realtime, result.status, result.granted_block);
                end
                else
                begin
                    want = queued_answers.pop_front();
                    if (result.status !== want.status ||
                        result.granted_block !== want.granted_block)
                    begin
                        miss_count++;
                        if (miss_count <= 10)
                            $display("%0t: mismatch exp st=%0d blk=%0d got st=%0d blk=%0d",
                                     $realtime, want.status, want.granted_block,
                                     result.status, result.granted_block);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    nfba_pkg::REG_REGION_START:
                    begin
                        region_start = cfg_data[BW-1:0];
                        cursor       = cfg_data[BW-1:0];
                    end
                    nfba_pkg::REG_TOTAL_BLOCKS: device_blocks = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                queued_answers.push_back(allocate_or_free(cmd));
        end
        errors      <= miss_count;
        outstanding <= queued_answers.size();
    end

endmodule

FILE: bench/next_fit_bitmap_block_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_fit_bitmap_block_allocator_tb
// Drives allocate and free commands and register writes into the allocator:
// a directed pass over region edges, wrap, full map and bad frees, then
// random traffic over several region settings with random idle bursts.
// ----------------------------------------------------------------------------
module next_fit_bitmap_block_allocator_tb;

    localparam int LIMIT = 3000;
    localparam int BW    = nfba_pkg::BLK_W;
    localparam int CW    = nfba_pkg::CFG_DATA_W;
    localparam logic [nfba_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped index

    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    nfba_pkg::cmd_t                    cmd;
    logic                              done;
    nfba_pkg::result_t                 result;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [nfba_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [CW-1:0]                     cfg_data;

    int               errors;
    int               outstanding;
    int               quiet;
    int               region_lo;
    int               region_hi;
    bit               calm;
    logic [BW-1:0]    live_blocks[$];  // granted blocks, free candidates

    next_fit_bitmap_block_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    next_fit_bitmap_block_allocator_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done && result.status == nfba_pkg::ST_OK && result.granted_block != '0)
            live_blocks.push_back(result.granted_block);
    end

    // ends the run when no beat moves on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    function automatic nfba_pkg::cmd_t mk(logic act, logic [BW-1:0] blk);
        nfba_pkg::cmd_t c;
        c.action = act;
        c.block_number = blk;
        return c;
    endfunction

    // start stays high after the beat; callers lower it when they stop
    task automatic issue(nfba_pkg::cmd_t c);
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic pause();
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            cmd.block_number <= 12'($urandom);
            repeat ($urandom_range(1, 18))
                @(posedge clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [nfba_pkg::CFG_IDX_W-1:0] idx, logic [CW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(int ds, int tot);
        settle();
        // bit 12 of a region start write is don't-care
        write_reg(nfba_pkg::REG_REGION_START, {1'($urandom), BW'(ds)});
        write_reg(nfba_pkg::REG_TOTAL_BLOCKS, CW'(tot));
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_SPARE, CW'($urandom));
        region_lo = ds;
        region_hi = (tot < 4096) ? tot : 4096;
    endtask

    task automatic random_item();
        nfba_pkg::cmd_t c;
        int   k;
        int   lo;
        int   hi;
        c.action = ($urandom_range(0, 99) < 55) ? nfba_pkg::ACT_ALLOC : nfba_pkg::ACT_FREE;
        c.block_number = 12'($urandom);
        if (c.action == nfba_pkg::ACT_FREE)
        begin
            k  = $urandom_range(0, 9);
            lo = (region_lo > 0) ? region_lo - 1 : 0;
            hi = (region_hi < 4096) ? region_hi : 4095;
            if (k < 5 && live_blocks.size() > 0)
            begin
                k = $urandom_range(0, live_blocks.size() - 1);
                c.block_number = live_blocks[k];
                live_blocks.delete(k);
            end
            else if (k < 9 && hi >= lo)
                c.block_number = BW'($urandom_range(lo, hi));
        end
        pause();
        issue(c);
    endtask

    initial
    begin
        int ds_pick;
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        calm      = 1'b1;
        region_lo = int'(nfba_pkg::REGION_START_RST);
        region_hi = 4096;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        // reset region: grants from the cursor, double free, a free below the region and of the unused last block
        issue(mk(nfba_pkg::ACT_ALLOC, 12'd0));
        issue(mk(nfba_pkg::ACT_ALLOC, 12'd0));
        issue(mk(nfba_pkg::ACT_FREE, 12'd1));
        issue(mk(nfba_pkg::ACT_FREE, 12'd1));
        issue(mk(nfba_pkg::ACT_FREE, 12'd0));
        issue(mk(nfba_pkg::ACT_FREE, 12'hFFF));
        issue(mk(nfba_pkg::ACT_ALLOC, 12'd0));
        // shrink the device under the cursor, fill up, wrap
        settle();
        write_reg(nfba_pkg::REG_TOTAL_BLOCKS, 13'd3);
        issue(mk(nfba_pkg::ACT_ALLOC, 12'd0));
        issue(mk(nfba_pkg::ACT_ALLOC, 12'd0));
        issue(mk(nfba_pkg::ACT_FREE, 12'd3));
        issue(mk(nfba_pkg::ACT_FREE, 12'd2));
        issue(mk(nfba_pkg::ACT_ALLOC, 12'd0));
        // region holding only block zero
        configure(0, 1);
        issue(mk(nfba_pkg::ACT_ALLOC, 12'd0));
        issue(mk(nfba_pkg::ACT_ALLOC, 12'd0));
        issue(mk(nfba_pkg::ACT_FREE, 12'd0));
        // last block, device size above the map
        configure(4095, 8191);
        issue(mk(nfba_pkg::ACT_ALLOC, 12'hFFF));
        issue(mk(nfba_pkg::ACT_FREE, 12'hFFF));
        // empty device, then empty region
        configure(5, 0);
        issue(mk(nfba_pkg::ACT_ALLOC, 12'd0));
        issue(mk(nfba_pkg::ACT_FREE, 12'd5));
        configure(10, 10);
        issue(mk(nfba_pkg::ACT_ALLOC, 12'd0));
        issue(mk(nfba_pkg::ACT_FREE, 12'd10));

        calm = 1'b0;
        for (int p = 0; p < 7; p++)
        begin
            ds_pick = $urandom_range(0, 4080);
            case (p)
                0: configure(0, $urandom_range(1, 40));
                1: configure(ds_pick % 200 + 1, ds_pick % 200 + 1 + $urandom_range(1, 48));
                2: configure(0, 8191);
                3: configure($urandom_range(4000, 4095), $urandom_range(4096, 8191));
                4: configure($urandom_range(0, 4095), $urandom_range(0, 8191));
                5: configure(ds_pick, ds_pick + $urandom_range(1, 64));
                default:
                begin
                    configure(ds_pick, ds_pick + $urandom_range(2, 30));
                    calm = 1'b1;
                end
            endcase
            repeat (150)
                random_item();
        end

        settle();
        repeat (80)
            @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
src/nfba_pkg.sv
src/nfba_div.sv
src/nfba_scan.sv
src/next_fit_bitmap_block_allocator.sv
bench/next_fit_bitmap_block_allocator_checker.sv
bench/next_fit_bitmap_block_allocator_tb.sv
